// ===== rtl/core/x86alu_pkg.sv =====
// Shared types, codes and helper functions for the x86 integer ALU.
package x86alu_pkg;

    // Operation codes of the request
    typedef enum logic [4:0] {
        OP_ADD  = 5'd0,
        OP_ADC  = 5'd1,
        OP_SUB  = 5'd2,
        OP_SBB  = 5'd3,
        OP_MUL  = 5'd4,
        OP_IMUL = 5'd5,
        OP_DIV  = 5'd6,
        OP_IDIV = 5'd7,
        OP_MOD  = 5'd8,
        OP_IMOD = 5'd9,
        OP_AND  = 5'd10,
        OP_OR   = 5'd11,
        OP_XOR  = 5'd12,
        OP_SHL  = 5'd13,
        OP_SAL  = 5'd14,
        OP_SHR  = 5'd15,
        OP_SAR  = 5'd16
    } t_op;

    // Execution class chosen by the front end
    typedef enum logic [2:0] {
        CLS_ADD,
        CLS_SUB,
        CLS_MUL,
        CLS_IMUL,
        CLS_DIV,
        CLS_LOGIC,
        CLS_SHIFT,
        CLS_NONE
    } t_cls;

    // Operand size codes (code 3 is folded to 32 bits by the front end)
    localparam logic [1:0] SZ_8  = 2'd0;
    localparam logic [1:0] SZ_16 = 2'd1;
    localparam logic [1:0] SZ_32 = 2'd2;

    localparam logic [31:0] MASK32 = 32'hFFFF_FFFF;
    localparam logic [31:0] ONE32  = 32'h0000_0001;

    typedef struct packed {
        logic cf;
        logic pf;
        logic zf;
        logic sf;
        logic of;
    } t_flags;

    // Decoded request passed from front to back
    typedef struct packed {
        t_cls        cls;
        t_op         op;
        logic [1:0]  sz;
        logic [31:0] d;
        logic [31:0] s;
        logic [63:0] div_mag;
        logic [31:0] div_sor;
        logic        neg_q;
        logic        neg_r;
        logic        want_rem;
        logic        zero_div;
        logic        shift_big;
        logic [5:0]  shift_cnt;
    } t_work;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [31:0] divisor;
        logic [5:0]  steps;
    } t_div_cmd;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [31:0] quot;
        logic [31:0] rem;
    } t_div_stat;

    function automatic logic [31:0] size_mask(input logic [1:0] sz);
        logic [31:0] m;
        case (sz)
            SZ_8:    m = 32'h0000_00FF;
            SZ_16:   m = 32'h0000_FFFF;
            default: m = MASK32;
        endcase
        return m;
    endfunction

    function automatic logic [63:0] wide_mask(input logic [1:0] sz);
        logic [63:0] m;
        case (sz)
            SZ_8:    m = 64'h0000_0000_0000_FFFF;
            SZ_16:   m = {32'd0, MASK32};
            default: m = {MASK32, MASK32};
        endcase
        return m;
    endfunction

    function automatic logic [5:0] size_bits(input logic [1:0] sz);
        logic [5:0] n;
        case (sz)
            SZ_8:    n = 6'd8;
            SZ_16:   n = 6'd16;
            default: n = 6'd32;
        endcase
        return n;
    endfunction

    function automatic logic sign_at(input logic [31:0] v, input logic [1:0] sz);
        logic b;
        case (sz)
            SZ_8:    b = v[7];
            SZ_16:   b = v[15];
            default: b = v[31];
        endcase
        return b;
    endfunction

    // Bit just above the operand size (carry out position)
    function automatic logic bit_above(input logic [32:0] v, input logic [1:0] sz);
        logic b;
        case (sz)
            SZ_8:    b = v[8];
            SZ_16:   b = v[16];
            default: b = v[32];
        endcase
        return b;
    endfunction

    function automatic logic [31:0] sext32(input logic [31:0] v, input logic [1:0] sz);
        logic [31:0] x;
        case (sz)
            SZ_8:    x = {{24{v[7]}}, v[7:0]};
            SZ_16:   x = {{16{v[15]}}, v[15:0]};
            default: x = v;
        endcase
        return x;
    endfunction

    // Update PF, ZF and SF from a masked result
    function automatic t_flags res_flags(input t_flags f, input logic [31:0] r,
                                         input logic [1:0] sz);
        t_flags o;
        o    = f;
        o.pf = ~(^r[7:0]);
        o.zf = (r == 32'd0);
        o.sf = sign_at(r, sz);
        return o;
    endfunction

endpackage

// ===== rtl/core/x86alu_front.sv =====
// Front end: accepts requests, classifies them and prepares operands.
module x86alu_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [4:0]          i_operation,
    input  logic [31:0]         i_source_operand,
    input  logic [63:0]         i_dest_operand,
    input  logic [1:0]          i_size_select,
    input  logic                i_full,
    output logic                o_push,
    output x86alu_pkg::t_work   o_work
);

    x86alu_pkg::t_op   w_op;
    logic [1:0]        w_sz;
    logic [31:0]       w_m;
    logic [31:0]       w_s;
    logic [31:0]       w_d;
    logic [63:0]       w_dd;
    logic [63:0]       w_ddext;
    logic              w_dd_sign;
    logic              w_sgn;
    logic              w_nd;
    logic              w_ns;
    logic [63:0]       w_md;
    logic [31:0]       w_ms;
    logic              r_seen;

    // Take a request whenever the queue has room and reset is over
    assign o_in_ready = r_seen & ~i_full;
    assign o_push     = i_in_valid & o_in_ready;

    // Track that the front has left reset (used only to gate the ready path)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else begin
            r_seen <= 1'b1;
        end
    end

    // Normalize size and mask operands
    always_comb begin
        w_op  = x86alu_pkg::t_op'(i_operation);
        w_sz  = (i_size_select == 2'd3) ? x86alu_pkg::SZ_32 : i_size_select;
        w_m   = x86alu_pkg::size_mask(w_sz);
        w_s   = i_source_operand & w_m;
        w_d   = i_dest_operand[31:0] & w_m;
        w_dd  = i_dest_operand & x86alu_pkg::wide_mask(w_sz);
        case (w_sz)
            x86alu_pkg::SZ_8: begin
                w_dd_sign = w_dd[15];
                w_ddext   = {{48{w_dd[15]}}, w_dd[15:0]};
            end
            x86alu_pkg::SZ_16: begin
                w_dd_sign = w_dd[31];
                w_ddext   = {{32{w_dd[31]}}, w_dd[31:0]};
            end
            default: begin
                w_dd_sign = w_dd[63];
                w_ddext   = w_dd;
            end
        endcase
        w_sgn = (w_op == x86alu_pkg::OP_IDIV) || (w_op == x86alu_pkg::OP_IMOD);
        w_nd  = w_sgn & w_dd_sign;
        w_ns  = w_sgn & x86alu_pkg::sign_at(w_s, w_sz);
        w_md  = w_nd ? (64'd0 - w_ddext) : w_dd;
        w_ms  = w_ns ? (32'd0 - x86alu_pkg::sext32(w_s, w_sz)) : w_s;
    end

    // Classify and build the work item
    always_comb begin
        o_work     = '0;
        o_work.op  = w_op;
        o_work.sz  = w_sz;
        o_work.d   = w_d;
        o_work.s   = w_s;
        unique case (w_op) inside
            x86alu_pkg::OP_ADD, x86alu_pkg::OP_ADC:   o_work.cls = x86alu_pkg::CLS_ADD;
            x86alu_pkg::OP_SUB, x86alu_pkg::OP_SBB:   o_work.cls = x86alu_pkg::CLS_SUB;
            x86alu_pkg::OP_MUL:                       o_work.cls = x86alu_pkg::CLS_MUL;
            x86alu_pkg::OP_IMUL:                      o_work.cls = x86alu_pkg::CLS_IMUL;
            x86alu_pkg::OP_DIV, x86alu_pkg::OP_IDIV,
            x86alu_pkg::OP_MOD, x86alu_pkg::OP_IMOD:  o_work.cls = x86alu_pkg::CLS_DIV;
            x86alu_pkg::OP_AND, x86alu_pkg::OP_OR,
            x86alu_pkg::OP_XOR:                       o_work.cls = x86alu_pkg::CLS_LOGIC;
            x86alu_pkg::OP_SHL, x86alu_pkg::OP_SAL,
            x86alu_pkg::OP_SHR, x86alu_pkg::OP_SAR:   o_work.cls = x86alu_pkg::CLS_SHIFT;
            default:                                  o_work.cls = x86alu_pkg::CLS_NONE;
        endcase
        // Left-justify the dividend magnitude for the MSB-first divider
        case (w_sz)
            x86alu_pkg::SZ_8:  o_work.div_mag = w_md << 48;
            x86alu_pkg::SZ_16: o_work.div_mag = w_md << 32;
            default:           o_work.div_mag = w_md;
        endcase
        o_work.div_sor   = w_ms;
        o_work.neg_q     = w_nd ^ w_ns;
        o_work.neg_r     = w_nd;
        o_work.want_rem  = (w_op == x86alu_pkg::OP_MOD) || (w_op == x86alu_pkg::OP_IMOD);
        o_work.zero_div  = (w_s == 32'd0);
        o_work.shift_big = w_s > {26'd0, x86alu_pkg::size_bits(w_sz)};
        o_work.shift_cnt = w_s[5:0];
    end

endmodule

// ===== rtl/core/x86alu_fifo.sv =====
// Short queue of decoded requests between front and back.
module x86alu_fifo #(
    parameter int DEPTH = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  x86alu_pkg::t_work  i_data,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_valid,
    output x86alu_pkg::t_work  o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    x86alu_pkg::t_work r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    // Store a request
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/x86alu_div.sv =====
// Radix-4 restoring divider: two quotient bits per cycle, MSB first.
module x86alu_div (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  x86alu_pkg::t_div_cmd   i_cmd,
    output x86alu_pkg::t_div_stat  o_stat
);

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [63:0] r_dvd;
    logic [31:0] r_dsor;
    logic [31:0] r_rem;
    logic [31:0] r_quo;

    logic [32:0] w_t1;
    logic [32:0] w_t2;
    logic        w_ge1;
    logic        w_ge2;
    logic [31:0] w_r1;
    logic [31:0] w_r2;

    // Two dependent subtract steps
    always_comb begin
        w_t1  = {r_rem, r_dvd[63]};
        w_ge1 = w_t1 >= {1'b0, r_dsor};
        w_r1  = w_ge1 ? 32'(w_t1 - {1'b0, r_dsor}) : w_t1[31:0];
        w_t2  = {w_r1, r_dvd[62]};
        w_ge2 = w_t2 >= {1'b0, r_dsor};
        w_r2  = w_ge2 ? 32'(w_t2 - {1'b0, r_dsor}) : w_t2[31:0];
    end

    // Control: start, count down, flag done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_cmd.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= i_cmd.steps;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == 6'd1) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Datapath: shift dividend, accumulate quotient
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_dvd  <= i_cmd.dividend;
            r_dsor <= i_cmd.divisor;
            r_rem  <= '0;
            r_quo  <= '0;
        end else if (r_busy) begin
            r_dvd <= r_dvd << 2;
            r_rem <= w_r2;
            r_quo <= {r_quo[29:0], w_ge1, w_ge2};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_stat.quot = r_quo;
    assign o_stat.rem  = r_rem;

endmodule

// ===== rtl/core/x86alu_back.sv =====
// Back end: executes queued requests, keeps the flags and holds the result.
module x86alu_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_head_valid,
    input  x86alu_pkg::t_work      i_head,
    output logic                   o_pop,
    output x86alu_pkg::t_div_cmd   o_div_cmd,
    input  x86alu_pkg::t_div_stat  i_div_stat,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [63:0]            o_result_value,
    output x86alu_pkg::t_flags     o_flags,
    output logic                   o_divide_error
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_MUL  = 3'b010,
        ST_DIV  = 3'b100
    } t_state;

    t_state              r_state;
    t_state              n_state;
    x86alu_pkg::t_flags  r_flags;
    x86alu_pkg::t_work   r_cur;
    logic [63:0]         r_prod;
    logic                r_out_valid;
    logic [63:0]         r_res;
    logic                r_derr;

    logic                w_out_free;
    logic                w_fin;
    logic [63:0]         w_res;
    x86alu_pkg::t_flags  w_flg;
    logic                w_derr;

    // Combinational datapath on the queue head
    logic [31:0]         a_m;
    logic                a_cin;
    logic [32:0]         a_sum;
    logic [32:0]         a_sub;
    logic [31:0]         a_r;
    x86alu_pkg::t_flags  a_f;
    logic                a_derr;
    logic [63:0]         a_shl;
    logic [31:0]         a_sx;
    logic [31:0]         a_ext;
    logic                a_fill;
    logic [64:0]         a_y;
    logic [64:0]         a_z;
    logic                a_sar;

    // Multiplier operands
    logic [32:0]         m_a;
    logic [32:0]         m_b;
    logic [65:0]         m_p;

    // Finish values for multi-cycle work
    logic [63:0]         f_prod;
    logic                f_hi;
    logic [31:0]         f_q;
    logic [31:0]         f_r;
    logic [31:0]         f_m;

    assign w_out_free = ~r_out_valid | i_out_ready;

    // Add, subtract, logic and shift on the head
    always_comb begin
        a_m    = x86alu_pkg::size_mask(i_head.sz);
        a_cin  = ((i_head.op == x86alu_pkg::OP_ADC) || (i_head.op == x86alu_pkg::OP_SBB))
                 & r_flags.cf;
        a_sum  = {1'b0, i_head.d} + {1'b0, i_head.s} + {32'd0, a_cin};
        a_sub  = {1'b0, i_head.s} + {32'd0, a_cin};
        a_shl  = {32'd0, i_head.d} << i_head.shift_cnt;
        a_sar  = (i_head.op == x86alu_pkg::OP_SAR);
        a_sx   = x86alu_pkg::sext32(i_head.d, i_head.sz);
        a_ext  = a_sar ? a_sx : i_head.d;
        a_fill = a_sar & a_sx[31];
        a_y    = {{32{a_fill}}, a_ext, 1'b0};
        a_z    = a_y >> i_head.shift_cnt;
        a_r    = '0;
        a_f    = r_flags;
        a_derr = 1'b0;
        case (i_head.cls)
            x86alu_pkg::CLS_ADD: begin
                a_r    = a_sum[31:0] & a_m;
                a_f.cf = x86alu_pkg::bit_above(a_sum, i_head.sz);
                a_f.of = x86alu_pkg::sign_at(~(i_head.d ^ i_head.s) & (i_head.d ^ a_r),
                                             i_head.sz);
                a_f    = x86alu_pkg::res_flags(a_f, a_r, i_head.sz);
            end
            x86alu_pkg::CLS_SUB: begin
                a_r    = (i_head.d - a_sub[31:0]) & a_m;
                a_f.cf = {1'b0, i_head.d} < a_sub;
                a_f.of = x86alu_pkg::sign_at((i_head.d ^ i_head.s) & (i_head.d ^ a_r),
                                             i_head.sz);
                a_f    = x86alu_pkg::res_flags(a_f, a_r, i_head.sz);
            end
            x86alu_pkg::CLS_LOGIC: begin
                case (i_head.op)
                    x86alu_pkg::OP_AND: a_r = i_head.d & i_head.s;
                    x86alu_pkg::OP_OR:  a_r = i_head.d | i_head.s;
                    default:            a_r = i_head.d ^ i_head.s;
                endcase
                a_f.cf = 1'b0;
                a_f.of = 1'b0;
                a_f    = x86alu_pkg::res_flags(a_f, a_r, i_head.sz);
            end
            x86alu_pkg::CLS_SHIFT: begin
                if (i_head.shift_big) begin
                    a_r    = a_fill ? a_m : 32'd0;
                    a_f.cf = a_fill;
                end else if (i_head.shift_cnt == 6'd0) begin
                    a_r = i_head.d;
                end else if (i_head.op == x86alu_pkg::OP_SHL ||
                             i_head.op == x86alu_pkg::OP_SAL) begin
                    a_r    = a_shl[31:0] & a_m;
                    a_f.cf = x86alu_pkg::bit_above(a_shl[32:0], i_head.sz);
                end else begin
                    a_r    = a_z[32:1] & a_m;
                    a_f.cf = a_z[0];
                end
                a_f = x86alu_pkg::res_flags(a_f, a_r, i_head.sz);
            end
            x86alu_pkg::CLS_DIV: begin
                a_derr = 1'b1;
            end
            default: begin
                a_r = '0;
            end
        endcase
    end

    // One signed 33x33 multiply covers mul and imul
    always_comb begin
        if (i_head.cls == x86alu_pkg::CLS_IMUL) begin
            m_a = {x86alu_pkg::sext32(i_head.d, i_head.sz), 1'b0} >>> 0;
            m_a = {m_a[32], m_a[32:1]};
            m_b = {1'b0, x86alu_pkg::sext32(i_head.s, i_head.sz)};
            m_b[32] = m_b[31];
        end else begin
            m_a = {1'b0, i_head.d};
            m_b = {1'b0, i_head.s};
        end
        m_p = 66'($signed(m_a) * $signed(m_b));
    end

    // Finish values from the product and divider registers
    always_comb begin
        f_prod = r_prod & x86alu_pkg::wide_mask(r_cur.sz);
        case (r_cur.sz)
            x86alu_pkg::SZ_8:  f_hi = |f_prod[15:8];
            x86alu_pkg::SZ_16: f_hi = |f_prod[31:16];
            default:           f_hi = |f_prod[63:32];
        endcase
        f_m = x86alu_pkg::size_mask(r_cur.sz);
        f_q = r_cur.neg_q ? (32'd0 - i_div_stat.quot) : i_div_stat.quot;
        f_r = r_cur.neg_r ? (32'd0 - i_div_stat.rem) : i_div_stat.rem;
    end

    // Sequence requests through the back end
    always_comb begin
        n_state             = r_state;
        o_pop               = 1'b0;
        w_fin               = 1'b0;
        w_res               = '0;
        w_flg               = r_flags;
        w_derr              = 1'b0;
        o_div_cmd.start     = 1'b0;
        o_div_cmd.dividend  = i_head.div_mag;
        o_div_cmd.divisor   = i_head.div_sor;
        o_div_cmd.steps     = x86alu_pkg::size_bits(i_head.sz);
        unique case (r_state)
            ST_IDLE: begin
                if (i_head_valid) begin
                    if (i_head.cls == x86alu_pkg::CLS_MUL ||
                        i_head.cls == x86alu_pkg::CLS_IMUL) begin
                        o_pop   = 1'b1;
                        n_state = ST_MUL;
                    end else if (i_head.cls == x86alu_pkg::CLS_DIV && !i_head.zero_div) begin
                        o_pop           = 1'b1;
                        o_div_cmd.start = 1'b1;
                        n_state         = ST_DIV;
                    end else if (w_out_free) begin
                        o_pop  = 1'b1;
                        w_fin  = 1'b1;
                        w_res  = {32'd0, a_r};
                        w_flg  = a_f;
                        w_derr = a_derr;
                    end
                end
            end
            ST_MUL: begin
                if (w_out_free) begin
                    w_fin = 1'b1;
                    w_res = f_prod;
                    if (r_cur.cls == x86alu_pkg::CLS_MUL) begin
                        w_flg.cf = f_hi;
                        w_flg.of = f_hi;
                    end
                    n_state = ST_IDLE;
                end
            end
            ST_DIV: begin
                if (i_div_stat.done && w_out_free) begin
                    w_fin   = 1'b1;
                    w_res   = {32'd0, (r_cur.want_rem ? f_r : f_q) & f_m};
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Hold state, flags and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_flags     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_fin) begin
                r_flags     <= w_flg;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Capture payloads
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur  <= i_head;
            r_prod <= m_p[63:0];
        end
        if (w_fin) begin
            r_res  <= w_res;
            r_derr <= w_derr;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_res;
    assign o_flags        = r_flags;
    assign o_divide_error = r_derr;

`ifndef ASSERT_OFF
    a_flags_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_fin |=> $stable(r_flags))
        else $error("flags changed without a finished request");
    a_div_alive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (i_div_stat.busy || i_div_stat.done))
        else $error("waiting on an idle divider");
    a_derr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_derr) |-> (r_res == 64'd0))
        else $error("divide error with nonzero result");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> $stable(r_res))
        else $error("pending result overwritten");
`endif

endmodule

// ===== rtl/core/x86_integer_alu_with_flags.sv =====
// Top level of the x86 integer ALU with flags register.
//
//   channel   direction   handshake                 payload
//   in        to block    i_in_valid / o_in_ready   operation, operands, size
//   out       from block  o_out_valid / i_out_ready result, CF PF ZF SF OF, divide error
//
// add, adc, sub, sbb, logic and shift are computed on the queue head in the back end;
// mul and imul go through one registered 33x33 multiply; div, idiv, mod and imod
// run 8, 16 or 32 iterations of the radix-4 divider, by operand size.
// The front end decodes into a QUEUE_DEPTH-entry queue, so requests are taken
// while the back end works or the result register waits.
// Reset clears the flags, the queue and all valids; it is synchronous, active low.
module x86_integer_alu_with_flags #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [4:0]  i_operation,
    input  logic [31:0] i_source_operand,
    input  logic [63:0] i_dest_operand,
    input  logic [1:0]  i_size_select,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_result_value,
    output logic        o_carry_flag,
    output logic        o_parity_flag,
    output logic        o_zero_flag,
    output logic        o_sign_flag,
    output logic        o_overflow_flag,
    output logic        o_divide_error
);

    x86alu_pkg::t_work     w_work;
    x86alu_pkg::t_work     w_head;
    logic                  w_push;
    logic                  w_full;
    logic                  w_pop;
    logic                  w_head_valid;
    x86alu_pkg::t_div_cmd  w_div_cmd;
    x86alu_pkg::t_div_stat w_div_stat;
    x86alu_pkg::t_flags    w_flags;

    x86alu_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_operation      (i_operation),
        .i_source_operand (i_source_operand),
        .i_dest_operand   (i_dest_operand),
        .i_size_select    (i_size_select),
        .i_full           (w_full),
        .o_push           (w_push),
        .o_work           (w_work)
    );

    x86alu_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_work),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_head_valid),
        .o_data  (w_head)
    );

    x86alu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_div_cmd),
        .o_stat  (w_div_stat)
    );

    x86alu_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head_valid   (w_head_valid),
        .i_head         (w_head),
        .o_pop          (w_pop),
        .o_div_cmd      (w_div_cmd),
        .i_div_stat     (w_div_stat),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_result_value (o_result_value),
        .o_flags        (w_flags),
        .o_divide_error (o_divide_error)
    );

    assign o_carry_flag    = w_flags.cf;
    assign o_parity_flag   = w_flags.pf;
    assign o_zero_flag     = w_flags.zf;
    assign o_sign_flag     = w_flags.sf;
    assign o_overflow_flag = w_flags.of;

endmodule
